>>> hdl/uvs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the UV sphere mesh generator.
// No dependencies; every other file refers to it by scoped names.
package uvs_pkg;

    localparam int MAX_STEPS    = 256;
    localparam int MIN_STEPS    = 4;
    localparam int STEP_W       = 9;
    localparam int IDX_W        = 8;
    localparam int CW           = 34;
    localparam int PW           = 2 * CW;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = 4;

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [CW-1:0] UNIT_Q30  = 34'sd1073741824;

    localparam logic [8:0]  RESET_STEPS  = 9'd24;
    localparam logic [30:0] RESET_RADIUS = 31'd65536;
    localparam logic [29:0] RESET_ASTEP  = 30'd89478485;

    // register indexes
    localparam logic [1:0] REG_STEPS  = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_ASTEP  = 2'd2;

    // sweep phases
    localparam logic [2:0] PH_POLES = 3'd0;
    localparam logic [2:0] PH_RING  = 3'd1;
    localparam logic [2:0] PH_NORTH = 3'd2;
    localparam logic [2:0] PH_MID   = 3'd3;
    localparam logic [2:0] PH_SOUTH = 3'd4;
    localparam logic [2:0] PH_IDLE  = 3'd5;

    // item kinds
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CORDIC_T = 4'd1;
    localparam logic [3:0] OP_CORDIC_P = 4'd2;
    localparam logic [3:0] OP_POLE     = 4'd3;
    localparam logic [3:0] OP_MUL_NX   = 4'd4;
    localparam logic [3:0] OP_MUL_NY   = 4'd5;
    localparam logic [3:0] OP_MUL_PX   = 4'd6;
    localparam logic [3:0] OP_MUL_PY   = 4'd7;
    localparam logic [3:0] OP_MUL_PZ   = 4'd8;

    typedef struct packed {
        logic [3:0]       op;
        logic [IDX_W-1:0] ring;
        logic [IDX_W-1:0] col;
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_busy;
    } dp_status_t;

    typedef struct packed {
        logic        load;
        logic [1:0]  kind;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic        last;
    } ctrl_res_t;

    function automatic logic signed [CW-1:0] atan_val(input logic [ITER_W-1:0] k);
        logic signed [CW-1:0] v;
        unique case (k)
            4'd0:    v = 34'sd536870912;
            4'd1:    v = 34'sd316933406;
            4'd2:    v = 34'sd167458907;
            4'd3:    v = 34'sd85004756;
            4'd4:    v = 34'sd42667331;
            4'd5:    v = 34'sd21354465;
            4'd6:    v = 34'sd10679838;
            4'd7:    v = 34'sd5340245;
            4'd8:    v = 34'sd2670163;
            4'd9:    v = 34'sd1335087;
            4'd10:   v = 34'sd667544;
            4'd11:   v = 34'sd333772;
            4'd12:   v = 34'sd166886;
            4'd13:   v = 34'sd83443;
            4'd14:   v = 34'sd41722;
            default: v = 34'sd20861;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/uvs_ctrl.sv
`timescale 1ns / 1ps
// Controller: sweep counters, triangle indices and the per-item sequencer
// that drives the datapath. Depends on uvs_pkg.
module uvs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  restart,
    input  logic [8:0]            steps,
    input  logic                  out_free,
    output uvs_pkg::dp_cmd_t      cmd,
    input  uvs_pkg::dp_status_t   status,
    output uvs_pkg::ctrl_res_t    res
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_WT    = 4'd2;
    localparam logic [3:0] ST_WP    = 4'd3;
    localparam logic [3:0] ST_NY    = 4'd4;
    localparam logic [3:0] ST_PX    = 4'd5;
    localparam logic [3:0] ST_PY    = 4'd6;
    localparam logic [3:0] ST_PZ    = 4'd7;
    localparam logic [3:0] ST_DRAIN = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] ring_reg, ring_next;
    logic [7:0] col_reg, col_next;
    logic       half_reg, half_next;

    logic        col_last, ring_last, ring_last2;
    logic [15:0] steps16, ring16, col16;
    logic [31:0] mid_prod, south_prod;
    logic [15:0] shift, ca, cb;

    assign steps16    = {7'd0, steps};
    assign ring16     = {8'd0, ring_reg};
    assign col16      = {8'd0, col_reg};
    assign col_last   = ({1'b0, col_reg} + 9'd1) >= steps;
    assign ring_last  = ({1'b0, ring_reg} + 9'd1) >= steps;
    assign ring_last2 = ({2'd0, ring_reg} + 10'd2) >= {1'b0, steps};
    assign mid_prod   = (ring16 - 16'd1) * steps16;
    assign south_prod = (steps16 - 16'd2) * steps16;

    always_comb
    begin
        unique case (phase_reg)
            uvs_pkg::PH_MID:   shift = 16'd2 + mid_prod[15:0];
            uvs_pkg::PH_SOUTH: shift = 16'd2 + south_prod[15:0];
            default:           shift = 16'd2;
        endcase
        ca = shift + col16;
        cb = col_last ? shift : ca + 16'd1;
    end

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ring_next  = ring_reg;
        col_next   = col_reg;
        half_next  = half_reg;
        cmd.op     = uvs_pkg::OP_NONE;
        cmd.ring   = ring_reg;
        cmd.col    = col_reg;
        res        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DISP;
                    if (restart)
                    begin
                        phase_next = uvs_pkg::PH_POLES;
                        ring_next  = '0;
                        col_next   = '0;
                        half_next  = 1'b0;
                    end
                end
            end
            ST_DISP:
            begin
                unique case (phase_reg)
                    uvs_pkg::PH_RING:
                    begin
                        cmd.op     = uvs_pkg::OP_CORDIC_T;
                        state_next = ST_WT;
                    end
                    uvs_pkg::PH_POLES:
                    begin
                        cmd.op     = uvs_pkg::OP_POLE;
                        state_next = ST_PX;
                    end
                    default: state_next = ST_EMIT;
                endcase
            end
            ST_WT:
            begin
                if (!status.cordic_busy)
                begin
                    cmd.op     = uvs_pkg::OP_CORDIC_P;
                    state_next = ST_WP;
                end
            end
            ST_WP:
            begin
                if (!status.cordic_busy)
                begin
                    cmd.op     = uvs_pkg::OP_MUL_NX;
                    state_next = ST_NY;
                end
            end
            ST_NY:
            begin
                cmd.op     = uvs_pkg::OP_MUL_NY;
                state_next = ST_PX;
            end
            ST_PX:
            begin
                cmd.op     = uvs_pkg::OP_MUL_PX;
                state_next = ST_PY;
            end
            ST_PY:
            begin
                cmd.op     = uvs_pkg::OP_MUL_PY;
                state_next = ST_PZ;
            end
            ST_PZ:
            begin
                cmd.op     = uvs_pkg::OP_MUL_PZ;
                state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (phase_reg)
                        uvs_pkg::PH_POLES:
                        begin
                            res.kind = uvs_pkg::KIND_VERTEX;
                            if (col_reg == 8'd0)
                                col_next = 8'd1;
                            else
                            begin
                                phase_next = uvs_pkg::PH_RING;
                                ring_next  = 8'd1;
                                col_next   = '0;
                            end
                        end
                        uvs_pkg::PH_RING:
                        begin
                            res.kind = uvs_pkg::KIND_VERTEX;
                            if (col_last)
                            begin
                                col_next = '0;
                                if (ring_last)
                                begin
                                    phase_next = uvs_pkg::PH_NORTH;
                                    ring_next  = '0;
                                end
                                else
                                    ring_next = ring_reg + 8'd1;
                            end
                            else
                                col_next = col_reg + 8'd1;
                        end
                        uvs_pkg::PH_NORTH:
                        begin
                            res.kind = uvs_pkg::KIND_TRI;
                            res.a    = ca;
                            res.b    = cb;
                            if (col_last)
                            begin
                                phase_next = uvs_pkg::PH_MID;
                                ring_next  = 8'd1;
                                col_next   = '0;
                                half_next  = 1'b0;
                            end
                            else
                                col_next = col_reg + 8'd1;
                        end
                        uvs_pkg::PH_MID:
                        begin
                            res.kind = uvs_pkg::KIND_TRI;
                            if (!half_reg)
                            begin
                                res.a     = ca;
                                res.b     = ca + steps16;
                                res.c     = cb;
                                half_next = 1'b1;
                            end
                            else
                            begin
                                res.a     = cb + steps16;
                                res.b     = cb;
                                res.c     = ca + steps16;
                                half_next = 1'b0;
                                if (col_last)
                                begin
                                    col_next = '0;
                                    if (ring_last2)
                                    begin
                                        phase_next = uvs_pkg::PH_SOUTH;
                                        ring_next  = '0;
                                    end
                                    else
                                        ring_next = ring_reg + 8'd1;
                                end
                                else
                                    col_next = col_reg + 8'd1;
                            end
                        end
                        uvs_pkg::PH_SOUTH:
                        begin
                            res.kind = uvs_pkg::KIND_TRI;
                            res.a    = ca;
                            res.b    = 16'd1;
                            res.c    = cb;
                            res.last = col_last;
                            if (col_last)
                            begin
                                phase_next = uvs_pkg::PH_IDLE;
                                col_next   = '0;
                            end
                            else
                                col_next = col_reg + 8'd1;
                        end
                        default: res.kind = uvs_pkg::KIND_IDLE;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= uvs_pkg::PH_POLES;
            ring_reg  <= '0;
            col_reg   <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ring_reg  <= ring_next;
            col_reg   <= col_next;
            half_reg  <= half_next;
        end
    end

endmodule

>>> hdl/uvs_dp.sv
`timescale 1ns / 1ps
// Datapath: iterative CORDIC sine/cosine, one shared multiplier with a
// registered product, and the vertex normal and position registers. Depends on uvs_pkg.
module uvs_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  uvs_pkg::dp_cmd_t      cmd,
    input  logic [29:0]           angle_step,
    input  logic [30:0]           radius,
    output uvs_pkg::dp_status_t   status,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic signed [31:0]    pos_z,
    output logic signed [15:0]    norm_x,
    output logic signed [15:0]    norm_y,
    output logic signed [15:0]    norm_z
);

    localparam int CW = uvs_pkg::CW;
    localparam int PW = uvs_pkg::PW;
    localparam logic signed [PW-1:0] POS_LIM = 68'sd2147483647;

    logic                          busy_reg;
    logic [uvs_pkg::ITER_W-1:0]    k_reg;
    logic                          flip_reg, dest_reg;
    logic signed [CW-1:0]          x_reg, y_reg, z_reg;
    logic signed [CW-1:0]          ct_reg, st_reg, cp_reg, sp_reg;
    logic signed [CW-1:0]          nx_reg, ny_reg, nz_reg;
    logic signed [PW-1:0]          prod_reg;
    logic [3:0]                    tag_reg;
    logic signed [31:0]            px_reg, py_reg, pz_reg;

    logic [8:0]            ang_mul;
    logic [38:0]           ang_full;
    logic [31:0]           ang;
    logic signed [CW-1:0]  dx, dy, at, x_nx, y_nx, z_nx, cos_v, sin_v;
    logic signed [CW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  rnd30;
    logic signed [31:0]    pos_sat;
    logic                  is_cordic, is_mul;

    function automatic logic signed [15:0] quant_norm(input logic signed [CW-1:0] n);
        logic signed [CW-1:0] t;
        logic signed [15:0]   q;
        t = (n + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
            q = 16'sd16384;
        else if (t < -34'sd16384)
            q = -16'sd16384;
        else
            q = 16'(t);
        return q;
    endfunction

    assign is_cordic = (cmd.op == uvs_pkg::OP_CORDIC_T) || (cmd.op == uvs_pkg::OP_CORDIC_P);
    assign is_mul    = (cmd.op == uvs_pkg::OP_MUL_NX) || (cmd.op == uvs_pkg::OP_MUL_NY)
                    || (cmd.op == uvs_pkg::OP_MUL_PX) || (cmd.op == uvs_pkg::OP_MUL_PY)
                    || (cmd.op == uvs_pkg::OP_MUL_PZ);

    assign ang_mul  = (cmd.op == uvs_pkg::OP_CORDIC_T) ? {1'b0, cmd.ring} : {cmd.col, 1'b0};
    assign ang_full = ang_mul * angle_step;
    assign ang      = ang_full[31:0];

    assign dx    = y_reg >>> k_reg;
    assign dy    = x_reg >>> k_reg;
    assign at    = uvs_pkg::atan_val(k_reg);
    assign x_nx  = z_reg[CW-1] ? x_reg + dx : x_reg - dx;
    assign y_nx  = z_reg[CW-1] ? y_reg - dy : y_reg + dy;
    assign z_nx  = z_reg[CW-1] ? z_reg + at : z_reg - at;
    assign cos_v = flip_reg ? -x_nx : x_nx;
    assign sin_v = flip_reg ? -y_nx : y_nx;

    always_comb
    begin
        mul_a = signed'({3'd0, radius});
        mul_b = nz_reg;
        unique case (cmd.op)
            uvs_pkg::OP_MUL_NX:
            begin
                mul_a = st_reg;
                mul_b = cp_reg;
            end
            uvs_pkg::OP_MUL_NY:
            begin
                mul_a = st_reg;
                mul_b = sp_reg;
            end
            uvs_pkg::OP_MUL_PX: mul_b = nx_reg;
            uvs_pkg::OP_MUL_PY: mul_b = ny_reg;
            default:            mul_b = nz_reg;
        endcase
    end

    assign rnd30 = (prod_reg + (68'sd1 <<< 29)) >>> 30;

    always_comb
    begin
        if (rnd30 > POS_LIM)
            pos_sat = 32'sd2147483647;
        else if (rnd30 < -POS_LIM)
            pos_sat = -32'sd2147483647;
        else
            pos_sat = 32'(rnd30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            tag_reg  <= uvs_pkg::OP_NONE;
        end
        else
        begin
            if (is_cordic)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 4'd1;
                if (k_reg == 4'(uvs_pkg::CORDIC_ITERS - 1))
                    busy_reg <= 1'b0;
            end
            tag_reg <= is_mul ? cmd.op : uvs_pkg::OP_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_cordic)
        begin
            flip_reg <= ang[31] ^ ang[30];
            dest_reg <= (cmd.op == uvs_pkg::OP_CORDIC_P);
            x_reg    <= uvs_pkg::CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= CW'(signed'({ang[30], ang[30:0]}));
        end
        else if (busy_reg)
        begin
            x_reg <= x_nx;
            y_reg <= y_nx;
            z_reg <= z_nx;
            if (k_reg == 4'(uvs_pkg::CORDIC_ITERS - 1))
            begin
                if (dest_reg)
                begin
                    cp_reg <= cos_v;
                    sp_reg <= sin_v;
                end
                else
                begin
                    ct_reg <= cos_v;
                    st_reg <= sin_v;
                end
            end
        end

        prod_reg <= mul_a * mul_b;

        if (cmd.op == uvs_pkg::OP_POLE)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= (cmd.col == 8'd0) ? uvs_pkg::UNIT_Q30 : -uvs_pkg::UNIT_Q30;
        end
        else if (cmd.op == uvs_pkg::OP_MUL_NX)
            nz_reg <= ct_reg;

        unique case (tag_reg)
            uvs_pkg::OP_MUL_NX: nx_reg <= rnd30[CW-1:0];
            uvs_pkg::OP_MUL_NY: ny_reg <= rnd30[CW-1:0];
            uvs_pkg::OP_MUL_PX: px_reg <= pos_sat;
            uvs_pkg::OP_MUL_PY: py_reg <= pos_sat;
            uvs_pkg::OP_MUL_PZ: pz_reg <= pos_sat;
            default: ;
        endcase
    end

    assign status.cordic_busy = busy_reg;
    assign pos_x  = px_reg;
    assign pos_y  = py_reg;
    assign pos_z  = pz_reg;
    assign norm_x = quant_norm(nx_reg);
    assign norm_y = quant_norm(ny_reg);
    assign norm_z = quant_norm(nz_reg);

endmodule

>>> hdl/uv_sphere_mesh_generator.sv
`timescale 1ns / 1ps
// UV sphere mesh generator: one mesh item per accepted request, in sweep order.
// A ring vertex needs two 16-iteration passes through the single CORDIC unit
// followed by five products on the shared multiplier; a pole vertex needs three
// products and a triangle or idle item none, and any item may wait for the
// output register. A new request is taken while a finished item still
// waits in the output register. Configuration writes are taken at any time but
// are meant for when no item is in flight.
// Depends on uvs_pkg, uvs_ctrl and uvs_dp.
module uv_sphere_mesh_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               restart,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         item_kind,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [15:0]        corner_a,
    output logic [15:0]        corner_b,
    output logic [15:0]        corner_c,
    output logic               final_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    logic [8:0]  ring_steps_reg;
    logic [30:0] radius_reg;
    logic [29:0] angle_step_reg;
    logic [8:0]  steps;

    uvs_pkg::dp_cmd_t    cmd;
    uvs_pkg::dp_status_t status;
    uvs_pkg::ctrl_res_t  res;

    logic signed [31:0] dp_px, dp_py, dp_pz;
    logic signed [15:0] dp_nx, dp_ny, dp_nz;
    logic               out_free, is_vtx;

    logic               valid_reg;
    logic [1:0]         kind_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic [15:0]        a_reg, b_reg, c_reg;
    logic               last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_steps_reg <= uvs_pkg::RESET_STEPS;
            radius_reg     <= uvs_pkg::RESET_RADIUS;
            angle_step_reg <= uvs_pkg::RESET_ASTEP;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                uvs_pkg::REG_STEPS:  ring_steps_reg <= cfg_data[8:0];
                uvs_pkg::REG_RADIUS: radius_reg     <= cfg_data;
                uvs_pkg::REG_ASTEP:  angle_step_reg <= cfg_data[29:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (ring_steps_reg < 9'(uvs_pkg::MIN_STEPS))
            steps = 9'(uvs_pkg::MIN_STEPS);
        else if (ring_steps_reg > 9'(uvs_pkg::MAX_STEPS))
            steps = 9'(uvs_pkg::MAX_STEPS);
        else
            steps = ring_steps_reg;
    end

    assign out_free = !valid_reg || result_ready;

    uvs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .restart    (restart),
        .steps      (steps),
        .out_free   (out_free),
        .cmd        (cmd),
        .status     (status),
        .res        (res)
    );

    uvs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .angle_step (angle_step_reg),
        .radius     (radius_reg),
        .status     (status),
        .pos_x      (dp_px),
        .pos_y      (dp_py),
        .pos_z      (dp_pz),
        .norm_x     (dp_nx),
        .norm_y     (dp_ny),
        .norm_z     (dp_nz)
    );

    assign is_vtx = (res.kind == uvs_pkg::KIND_VERTEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res.load)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            kind_reg <= res.kind;
            px_reg   <= is_vtx ? dp_px : '0;
            py_reg   <= is_vtx ? dp_py : '0;
            pz_reg   <= is_vtx ? dp_pz : '0;
            nx_reg   <= is_vtx ? dp_nx : '0;
            ny_reg   <= is_vtx ? dp_ny : '0;
            nz_reg   <= is_vtx ? dp_nz : '0;
            a_reg    <= res.a;
            b_reg    <= res.b;
            c_reg    <= res.c;
            last_reg <= res.last;
        end
    end

    assign result_valid = valid_reg;
    assign item_kind    = kind_reg;
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign pos_z        = pz_reg;
    assign norm_x       = nx_reg;
    assign norm_y       = ny_reg;
    assign norm_z       = nz_reg;
    assign corner_a     = a_reg;
    assign corner_b     = b_reg;
    assign corner_c     = c_reg;
    assign final_item   = last_reg;

endmodule

>>> hdl/uvs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the UV sphere mesh generator and the bind that
// attaches them. Depends on uvs_pkg and uv_sphere_mesh_generator.
module uvs_port_props (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [1:0]         item_kind,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] pos_z,
    input logic signed [15:0] norm_z,
    input logic [15:0]        corner_a,
    input logic               final_item
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request taken while another is in progress");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(item_kind)
        && $stable(pos_x) && $stable(corner_a) && $stable(final_item))
        else $error("stalled result changed");

    a_final_is_tri: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && final_item |-> item_kind == uvs_pkg::KIND_TRI)
        else $error("final flag on a non-triangle item");

    a_nonvertex_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && item_kind != uvs_pkg::KIND_VERTEX |->
        pos_x == 32'sd0 && pos_y == 32'sd0 && pos_z == 32'sd0 && norm_z == 16'sd0)
        else $error("geometry on a non-vertex item");

endmodule

bind uv_sphere_mesh_generator uvs_port_props u_uvs_port_props (.*);

>>> bench/uvs_checker.sv
`timescale 1ns / 1ps
// Checker for the UV sphere mesh generator: watches the item, result and
// configuration channels, predicts each mesh item and compares it field by field.
// Depends on uvs_pkg; hands its error count to the testbench top.
module uvs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic               restart,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic [1:0]         item_kind,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic [15:0]        corner_a,
    input  logic [15:0]        corner_b,
    input  logic [15:0]        corner_c,
    input  logic               final_item,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
        logic        last;
    } mesh_item_t;

    mesh_item_t mesh_queue[$];

    logic [8:0]  steps_reg;
    logic [30:0] radius_reg;
    logic [29:0] astep_reg;
    logic [2:0]  phase;
    logic [31:0] ring;
    logic [31:0] col;
    logic        half;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
        logic        flip;
        logic [31:0] r;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        r = flip ? ang + 32'h8000_0000 : ang;
        z = longint'($signed(r));
        x = 652032874;
        y = 0;
        for (int k = 0; k < 16; k++)
        begin
            dx = fshift(y, k);
            dy = fshift(x, k);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(uvs_pkg::atan_val(k[3:0]));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(uvs_pkg::atan_val(k[3:0]));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic mesh_item_t make_vertex(longint n0, longint n1, longint n2);
        mesh_item_t m;
        longint     nv[3];
        longint     p;
        longint     q;
        m = '0;
        m.kind = uvs_pkg::KIND_VERTEX;
        nv[0] = n0;
        nv[1] = n1;
        nv[2] = n2;
        for (int c = 0; c < 3; c++)
        begin
            p = clip(round_q(longint'(radius_reg) * nv[c], 30), 2147483647);
            q = clip(round_q(nv[c], 16), 16384);
            if (c == 0)
            begin
                m.px = p[31:0];
                m.nx = q[15:0];
            end
            else if (c == 1)
            begin
                m.py = p[31:0];
                m.ny = q[15:0];
            end
            else
            begin
                m.pz = p[31:0];
                m.nz = q[15:0];
            end
        end
        return m;
    endfunction

    function automatic mesh_item_t make_tri(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                             logic last);
        mesh_item_t m;
        m = '0;
        m.kind = uvs_pkg::KIND_TRI;
        m.ca = a[15:0];
        m.cb = b[15:0];
        m.cc = c[15:0];
        m.last = last;
        return m;
    endfunction

    task automatic predict_item(input logic rs);
        mesh_item_t  m;
        logic [31:0] steps;
        logic [31:0] i;
        logic [31:0] j;
        logic [31:0] sh;
        logic [31:0] a;
        logic [31:0] b;
        longint      ct;
        longint      st;
        longint      cp;
        longint      sp;
        steps = {23'd0, steps_reg};
        if (steps < uvs_pkg::MIN_STEPS)
            steps = uvs_pkg::MIN_STEPS;
        if (steps > uvs_pkg::MAX_STEPS)
            steps = uvs_pkg::MAX_STEPS;
        if (rs)
        begin
            phase = uvs_pkg::PH_POLES;
            ring = 0;
            col = 0;
            half = 0;
        end
        i = col;
        j = ring;
        m = '0;
        m.kind = uvs_pkg::KIND_IDLE;
        case (phase)
            uvs_pkg::PH_POLES:
            begin
                m = make_vertex(0, 0, (i == 0) ? 64'sd1073741824 : -64'sd1073741824);
                if (i == 0)
                    col = 1;
                else
                begin
                    phase = uvs_pkg::PH_RING;
                    ring = 1;
                    col = 0;
                end
            end
            uvs_pkg::PH_RING:
            begin
                sin_cos(j * astep_reg, ct, st);
                sin_cos(2 * i * astep_reg, cp, sp);
                m = make_vertex(round_q(st * cp, 30), round_q(st * sp, 30), ct);
                if (i + 1 >= steps)
                begin
                    col = 0;
                    if (j + 1 >= steps)
                    begin
                        phase = uvs_pkg::PH_NORTH;
                        ring = 0;
                    end
                    else
                        ring = (j + 1) & 32'hFF;
                end
                else
                    col = (i + 1) & 32'hFF;
            end
            uvs_pkg::PH_NORTH:
            begin
                a = 2 + i;
                b = (i + 1 < steps) ? a + 1 : 2;
                m = make_tri(a, b, 0, 1'b0);
                if (i + 1 >= steps)
                begin
                    phase = uvs_pkg::PH_MID;
                    ring = 1;
                    col = 0;
                    half = 0;
                end
                else
                    col = (i + 1) & 32'hFF;
            end
            uvs_pkg::PH_MID:
            begin
                sh = 2 + (j - 1) * steps;
                a = sh + i;
                b = (i + 1 < steps) ? a + 1 : sh;
                if (!half)
                begin
                    m = make_tri(a, a + steps, b, 1'b0);
                    half = 1;
                end
                else
                begin
                    m = make_tri(b + steps, b, a + steps, 1'b0);
                    half = 0;
                    if (i + 1 >= steps)
                    begin
                        col = 0;
                        if (j + 2 >= steps)
                        begin
                            phase = uvs_pkg::PH_SOUTH;
                            ring = 0;
                        end
                        else
                            ring = (j + 1) & 32'hFF;
                    end
                    else
                        col = (i + 1) & 32'hFF;
                end
            end
            uvs_pkg::PH_SOUTH:
            begin
                sh = 2 + (steps - 2) * steps;
                a = sh + i;
                b = (i + 1 < steps) ? a + 1 : sh;
                if (i + 1 >= steps)
                begin
                    m = make_tri(a, 1, b, 1'b1);
                    phase = uvs_pkg::PH_IDLE;
                    col = 0;
                end
                else
                begin
                    m = make_tri(a, 1, b, 1'b0);
                    col = (i + 1) & 32'hFF;
                end
            end
            default:
                m.kind = uvs_pkg::KIND_IDLE;
        endcase
        mesh_queue.push_back(m);
    endtask

    task automatic report(input string fld, input longint e, input longint g);
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, fld, e, g);
    endtask

    task automatic compare_item();
        mesh_item_t e;
        mesh_item_t g;
        g = {item_kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
             corner_a, corner_b, corner_c, final_item};
        if (mesh_queue.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result transfer, expected none, actual %h", $time, g);
            return;
        end
        e = mesh_queue.pop_front();
        if (e.kind != g.kind)
            report("item_kind", longint'(e.kind), longint'(g.kind));
        if (e.px != g.px)
            report("pos_x", longint'($signed(e.px)), longint'($signed(g.px)));
        if (e.py != g.py)
            report("pos_y", longint'($signed(e.py)), longint'($signed(g.py)));
        if (e.pz != g.pz)
            report("pos_z", longint'($signed(e.pz)), longint'($signed(g.pz)));
        if (e.nx != g.nx)
            report("norm_x", longint'($signed(e.nx)), longint'($signed(g.nx)));
        if (e.ny != g.ny)
            report("norm_y", longint'($signed(e.ny)), longint'($signed(g.ny)));
        if (e.nz != g.nz)
            report("norm_z", longint'($signed(e.nz)), longint'($signed(g.nz)));
        if (e.ca != g.ca)
            report("corner_a", longint'(e.ca), longint'(g.ca));
        if (e.cb != g.cb)
            report("corner_b", longint'(e.cb), longint'(g.cb));
        if (e.cc != g.cc)
            report("corner_c", longint'(e.cc), longint'(g.cc));
        if (e.last != g.last)
            report("final_item", longint'(e.last), longint'(g.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg  <= uvs_pkg::RESET_STEPS;
            radius_reg <= uvs_pkg::RESET_RADIUS;
            astep_reg  <= uvs_pkg::RESET_ASTEP;
            phase      <= uvs_pkg::PH_POLES;
            ring       <= 0;
            col        <= 0;
            half       <= 0;
            errors     <= 0;
            mesh_queue.delete();
            pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
                compare_item();
            if (item_valid && item_ready)
                predict_item(restart);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    uvs_pkg::REG_STEPS:  steps_reg = cfg_data[8:0];
                    uvs_pkg::REG_RADIUS: radius_reg = cfg_data;
                    uvs_pkg::REG_ASTEP:  astep_reg = cfg_data[29:0];
                    default: ;
                endcase
            end
            pending = mesh_queue.size();
        end
    end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the UV sphere mesh generator: clock, reset, stimulus and verdict.
// Depends on uvs_pkg, the generator RTL and uvs_checker.
module testbench;

    localparam int LIMIT = 4000000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               item_valid = 0;
    logic               item_ready;
    logic               restart = 0;
    logic               result_valid;
    logic               result_ready = 0;
    logic [1:0]         item_kind;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic [15:0]        corner_a, corner_b, corner_c;
    logic               final_item;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = uvs_pkg::REG_STEPS;
    logic [30:0]        cfg_data = 0;
    int                 errors;
    int                 pending;
    int                 cycles = 0;
    int                 hold = 0;
    bit                 stall_en = 1;

    always #5 clk = ~clk;

    uv_sphere_mesh_generator i_dut (.*);

    uvs_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(9) < 6)
            return 0;
        if ($urandom_range(19) == 0)
            return int'($urandom_range(60, 20));
        return int'($urandom_range(4, 1));
    endfunction

    // random result-side back-pressure
    always @(posedge clk)
    begin
        if (!stall_en)
            result_ready <= 1'b1;
        else if (hold > 0)
        begin
            result_ready <= 1'b0;
            hold <= hold - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            if ($urandom_range(3) == 0)
                hold <= gap_len();
        end
    end

    task automatic send_item(input logic rs);
        int g;
        g = stall_en ? gap_len() : 0;
        if (g != 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        restart    <= rs;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        item_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mesh(input int st, input logic [30:0] rad, input logic [29:0] ast);
        write_reg(uvs_pkg::REG_STEPS, 31'(st));
        write_reg(uvs_pkg::REG_RADIUS, rad);
        write_reg(uvs_pkg::REG_ASTEP, {1'b0, ast});
    endtask

    initial
    begin
        int   n;
        int   st;
        logic [29:0] ast;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: smallest mesh, sweep into the middle band, then restarts
        set_mesh(4, 31'h7FFF_FFFF, 30'd536870912);
        send_item(1'b1);
        for (int k = 0; k < 22; k++)
            send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        // clamped step counts, zero and unit radius, a small and the largest angle step
        set_mesh(0, 31'd0, 30'd8388608);
        for (int k = 0; k < 12; k++)
            send_item(k == 0);
        set_mesh(511, 31'd1, 30'h3FFF_FFFF);
        for (int k = 0; k < 8; k++)
            send_item(k == 0);
        // random: small meshes, swept in part or in full, with random geometry
        n = 0;
        while (n < 1300)
        begin
            st = ($urandom_range(9) == 0) ? int'($urandom_range(511))
                                          : int'($urandom_range(10, 4));
            if ($urandom_range(3) == 0)
                ast = 30'($urandom_range(30'h3FFF_FFFF));
            else
                ast = 30'(32'h8000_0000 / ((st < 4) ? 4 : st));
            stall_en = ($urandom_range(4) != 0);
            set_mesh(st, ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(1 << 20)),
                     ast);
            send_item(1'b1);
            n++;
            for (int k = 0; k < $urandom_range(140, 20); k++)
            begin
                send_item($urandom_range(49) == 0);
                n++;
            end
        end
        item_valid <= 1'b0;
        stall_en = 1;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> uv_sphere_mesh_generator.f
hdl/uvs_pkg.sv
hdl/uvs_ctrl.sv
hdl/uvs_dp.sv
hdl/uv_sphere_mesh_generator.sv
hdl/uvs_checker.sv
bench/uvs_checker.sv
bench/testbench.sv
